FILE: rtl/core/u8v_pkg.sv
// UTF-8 validator package: sequence limits, lead-byte decode and the
// overlong check on a closed sequence. No dependencies.
`default_nettype none

package u8v_pkg;

  localparam int unsigned MaxSeqLen = 6;
  localparam int unsigned LenW      = 3;
  localparam int unsigned AccW      = 31;
  localparam int unsigned OnesW     = 4;

  typedef logic [LenW-1:0] seq_len_t;
  typedef logic [AccW-1:0] acc_t;
  typedef logic [OnesW-1:0] ones_t;

  // count of leading ones of a byte, 0 to 8
  function automatic ones_t lead_ones(input logic [7:0] b);
    ones_t n;
    n = '0;
    priority if (b[7:0] == 8'hFF) n = ones_t'(8);
    else if (b[7:1] == 7'h7F) n = ones_t'(7);
    else if (b[7:2] == 6'h3F) n = ones_t'(6);
    else if (b[7:3] == 5'h1F) n = ones_t'(5);
    else if (b[7:4] == 4'hF)  n = ones_t'(4);
    else if (b[7:5] == 3'h7)  n = ones_t'(3);
    else if (b[7:6] == 2'h3)  n = ones_t'(2);
    else if (b[7])            n = ones_t'(1);
    else                      n = ones_t'(0);
    return n;
  endfunction

  // A closed sequence of len bytes holds at most 5*len+1 bits, so only the
  // minimum bit length can fail: the code point needs a one in its top field.
  function automatic logic min_len_ok(input seq_len_t len, input acc_t acc,
                                      input logic allow_nul);
    logic ok;
    ok = 1'b0;
    unique case (len)
      3'd2:    ok = (acc[10:7] != '0) || ((acc == '0) && allow_nul);
      3'd3:    ok = (acc[15:11] != '0);
      3'd4:    ok = (acc[20:16] != '0);
      3'd5:    ok = (acc[25:21] != '0);
      3'd6:    ok = (acc[30:26] != '0);
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/utf8_byte_stream_validator_top.sv
// UTF-8 byte stream validator, original 6-byte form: top level.
// Depends on u8v_pkg.
`default_nettype none

// Usage
//  Input channel (in_valid_i / in_ready_o): one request per buffer byte.
//  byte_present_i qualifies data_byte_i; end_of_buffer_i marks the last
//  request of a buffer, which may carry no byte (empty buffer).
//  Output channel (out_valid_o / out_ready_i): one verdict request per
//  buffer, is_valid_o high when the buffer was well formed and no sequence
//  was left open.
//  Throughput: one byte per cycle while in_ready_o is high. Each byte is
//  decoded combinationally against the sequence state registers; the
//  leading-one count and the overlong test on the accumulator are the whole per-byte path.
//  Latency: the verdict is shown the cycle after the end request is taken,
//  unless an earlier verdict is still waiting to be taken.
//  Stall: results sit in an output register backed by a one-entry skid
//  register, so bytes keep flowing while a verdict waits; in_ready_o drops
//  only when both hold a verdict.
//  Reset: sequence state, error flag, output slot valid flags and the
//  modified-NUL enable clear at once; no start-up pass.
//  Configuration: cfg_we_i writes the modified-NUL enable from cfg_wdata_i.
module utf8_byte_stream_validator_top (
  input  wire  clk_i,
  input  wire  rst_ni,
  input  wire  cfg_we_i,
  input  wire  cfg_wdata_i,
  input  wire  in_valid_i,
  output logic in_ready_o,
  input  wire  [7:0] data_byte_i,
  input  wire  byte_present_i,
  input  wire  end_of_buffer_i,
  output logic out_valid_o,
  input  wire  out_ready_i,
  output logic is_valid_o
);
  import u8v_pkg::*;

  logic     allow_nul_q;
  seq_len_t len_q, len_d;
  seq_len_t seen_q, seen_d;
  acc_t     acc_q, acc_d;
  logic     err_q, err_d;

  logic out_valid_q, out_valid_d, out_bit_q, out_bit_d;
  logic skid_valid_q, skid_valid_d, skid_bit_q, skid_bit_d;

  ones_t    ones;
  seq_len_t seen_inc;
  acc_t     acc_shift;
  logic     take, push, pop, verdict;

  assign in_ready_o  = !skid_valid_q;
  assign take        = in_valid_i && in_ready_o;
  assign push        = take && end_of_buffer_i;
  assign pop         = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;
  assign is_valid_o  = out_bit_q;

  assign ones      = lead_ones(data_byte_i);
  assign seen_inc  = seen_q + seq_len_t'(1);
  assign acc_shift = {acc_q[AccW-7:0], data_byte_i[5:0]};

  // byte decode and sequence tracking
  always_comb begin
    len_d   = len_q;
    seen_d  = seen_q;
    acc_d   = acc_q;
    err_d   = err_q;
    verdict = 1'b0;
    if (take && byte_present_i && !err_q) begin
      if (len_q == '0) begin
        if (data_byte_i[7]) begin
          if (!data_byte_i[6] || ones > ones_t'(MaxSeqLen)) begin
            err_d = 1'b1; // stray continuation or too many leading ones
          end else begin
            len_d  = seq_len_t'(ones);
            seen_d = seq_len_t'(1);
            acc_d  = acc_t'(data_byte_i & (8'hFF >> ones));
          end
        end
      end else if (data_byte_i[7:6] != 2'b10) begin
        err_d = 1'b1;
      end else begin
        acc_d  = acc_shift;
        seen_d = seen_inc;
        if (seen_inc >= len_q) begin
          if (!min_len_ok(len_q, acc_shift, allow_nul_q)) begin
            err_d = 1'b1; // overlong
          end else begin
            len_d  = '0;
            seen_d = '0;
            acc_d  = '0;
          end
        end
      end
    end
    verdict = !err_d && (len_d == '0);
    if (push) begin
      len_d  = '0;
      seen_d = '0;
      acc_d  = '0;
      err_d  = 1'b0;
    end
  end

  // two-slot result buffer
  always_comb begin
    out_valid_d  = out_valid_q;
    out_bit_d    = out_bit_q;
    skid_valid_d = skid_valid_q;
    skid_bit_d   = skid_bit_q;
    if (pop || !out_valid_q) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_bit_d    = skid_bit_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push;
        out_bit_d   = verdict;
      end
    end else if (push) begin
      skid_valid_d = 1'b1;
      skid_bit_d   = verdict;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      allow_nul_q  <= 1'b0;
      len_q        <= '0;
      seen_q       <= '0;
      acc_q        <= '0;
      err_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        allow_nul_q <= cfg_wdata_i;
      end
      len_q        <= len_d;
      seen_q       <= seen_d;
      acc_q        <= acc_d;
      err_q        <= err_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_bit_q  <= out_bit_d;
    skid_bit_q <= skid_bit_d;
  end

endmodule

`default_nettype wire

FILE: rtl/core/u8v_checker.sv
// Port-level checks for the UTF-8 validator, bound to the top level.
// Depends on utf8_byte_stream_validator_top only through its ports.
`default_nettype none

module u8v_checker (
  input wire       clk_i,
  input wire       rst_ni,
  input wire       cfg_we_i,
  input wire       cfg_wdata_i,
  input wire       in_valid_i,
  input wire       in_ready_o,
  input wire [7:0] data_byte_i,
  input wire       byte_present_i,
  input wire       end_of_buffer_i,
  input wire       out_valid_o,
  input wire       out_ready_i,
  input wire       is_valid_o
);

  // an end request always yields a verdict next cycle
  a_end_gives_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && end_of_buffer_i) |=> out_valid_o)
    else $error("end request without verdict");

  // a byte request never invents a verdict
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !end_of_buffer_i && !out_valid_o) |=> !out_valid_o)
    else $error("verdict without end request");

  // input is only held off while verdicts are queued
  a_ready_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no pending verdict");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(is_valid_o)))
    else $error("stalled verdict dropped or changed");

endmodule

bind utf8_byte_stream_validator_top u8v_checker u_u8v_checker (.*);

`default_nettype wire
